### design/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg: shared types and constants for quaternion to euler conversion
// Holds the arctangent table, fixed-point widths and the controller
// command and status structs.
// ----------------------------------------------------------------------------
`default_nettype none
package qte_pkg;

    localparam int QUAT_FRAC_BITS  = 30;
    localparam int ANGLE_FRAC_BITS = 7;
    localparam int CORDIC_STEPS    = 16;
    localparam int WORK_FRAC       = 14;
    localparam int ACC_FRAC        = 24;
    localparam int RED             = QUAT_FRAC_BITS - WORK_FRAC;
    localparam int ACC_W           = 34;
    localparam int VEC_W           = 34;
    localparam int STEP_W          = 5;

    localparam logic signed [ACC_W-1:0] ACC_90 = ACC_W'(90 <<< ACC_FRAC);
    localparam logic signed [15:0] ANG_LIM = 16'(180 << ANGLE_FRAC_BITS);

    typedef enum logic [1:0] {
        SEL_ROLL  = 2'd0,
        SEL_PITCH = 2'd1,
        SEL_YAW   = 2'd2
    } angle_sel_t;

    typedef struct packed {
        logic       load_quat;
        logic       prod_step;
        logic       sqrt_start;
        logic       cordic_start;
        angle_sel_t sel;
        logic       store_angle;
        logic       finish;
        logic       rezero;
    } qte_cmd_t;

    typedef struct packed {
        logic sqrt_done;
        logic cordic_done;
    } qte_sts_t;

    function automatic logic signed [ACC_W-1:0] atan_tab(input logic [STEP_W-1:0] i);
        logic signed [ACC_W-1:0] r;
        unique case (i)
            5'd0:  r = 34'sd754974720;
            5'd1:  r = 34'sd445687602;
            5'd2:  r = 34'sd235489088;
            5'd3:  r = 34'sd119537938;
            5'd4:  r = 34'sd60000934;
            5'd5:  r = 34'sd30029717;
            5'd6:  r = 34'sd15018523;
            5'd7:  r = 34'sd7509720;
            5'd8:  r = 34'sd3754917;
            5'd9:  r = 34'sd1877466;
            5'd10: r = 34'sd938734;
            5'd11: r = 34'sd469367;
            5'd12: r = 34'sd234684;
            5'd13: r = 34'sd117342;
            5'd14: r = 34'sd58671;
            5'd15: r = 34'sd29335;
            5'd16: r = 34'sd14668;
            5'd17: r = 34'sd7334;
            5'd18: r = 34'sd3667;
            5'd19: r = 34'sd1833;
            5'd20: r = 34'sd917;
            5'd21: r = 34'sd458;
            5'd22: r = 34'sd229;
            5'd23: r = 34'sd115;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

### design/qte_cordic.sv
// ----------------------------------------------------------------------------
// qte_cordic: iterative atan2 in degrees
// Normalizes the vector by one shift a cycle, folds the left half plane,
// then runs one vectoring step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module qte_cordic
    import qte_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [VEC_W-1:0] vy,
    input  wire logic signed [VEC_W-1:0] vx,
    output logic                         done,
    output logic signed [15:0]           angle
);

    typedef enum logic [3:0] {
        C_IDLE = 4'b0001,
        C_NORM = 4'b0010,
        C_ITER = 4'b0100,
        C_DONE = 4'b1000
    } cstate_t;

    cstate_t                  state_reg, state_next;
    logic signed [VEC_W-1:0]  x_reg, x_next, y_reg, y_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic [STEP_W-1:0]        i_reg, i_next;

    logic [VEC_W-1:0]         ax, ay, m;
    logic signed [ACC_W-1:0]  rnd;
    logic signed [ACC_W-ACC_FRAC+ANGLE_FRAC_BITS-1:0] r;

    always_comb
    begin
        ax = x_reg[VEC_W-1] ? VEC_W'(-x_reg) : x_reg;
        ay = y_reg[VEC_W-1] ? VEC_W'(-y_reg) : y_reg;
        m  = (ax > ay) ? ax : ay;
    end

    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        acc_next   = acc_reg;
        i_next     = i_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    x_next   = vx;
                    y_next   = vy;
                    acc_next = '0;
                    i_next   = '0;
                    if (vx == '0 && vy == '0)
                        state_next = C_DONE;
                    else
                        state_next = C_NORM;
                end
            end
            C_NORM:
            begin
                if (m >= VEC_W'(1 << 29))
                begin
                    x_next = x_reg >>> 1;
                    y_next = y_reg >>> 1;
                end
                else if (m < VEC_W'(1 << 28))
                begin
                    x_next = x_reg <<< 1;
                    y_next = y_reg <<< 1;
                end
                else
                begin
                    // fold left half plane by a quarter turn
                    if (x_reg[VEC_W-1])
                    begin
                        if (!y_reg[VEC_W-1])
                        begin
                            x_next   = y_reg;
                            y_next   = -x_reg;
                            acc_next = ACC_90;
                        end
                        else
                        begin
                            x_next   = -y_reg;
                            y_next   = x_reg;
                            acc_next = -ACC_90;
                        end
                    end
                    state_next = C_ITER;
                end
            end
            C_ITER:
            begin
                if (y_reg > 0)
                begin
                    x_next   = x_reg + (y_reg >>> i_reg);
                    y_next   = y_reg - (x_reg >>> i_reg);
                    acc_next = acc_reg + atan_tab(i_reg);
                end
                else
                begin
                    x_next   = x_reg - (y_reg >>> i_reg);
                    y_next   = y_reg + (x_reg >>> i_reg);
                    acc_next = acc_reg - atan_tab(i_reg);
                end
                i_next = i_reg + 1'b1;
                if (i_reg == STEP_W'(CORDIC_STEPS - 1))
                    state_next = C_DONE;
            end
            C_DONE:
                state_next = C_IDLE;
            default:
                state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= C_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        acc_reg <= acc_next;
        i_reg   <= i_next;
    end

    always_comb
    begin
        rnd = acc_reg + ACC_W'(1 << (ACC_FRAC - 1 - ANGLE_FRAC_BITS));
        r   = rnd[ACC_W-1:ACC_FRAC-ANGLE_FRAC_BITS];
        if (r > ANG_LIM)
            angle = ANG_LIM;
        else if (r < -ANG_LIM)
            angle = -ANG_LIM;
        else
            angle = r[15:0];
        done = (state_reg == C_DONE);
    end

endmodule
`default_nettype wire

### design/qte_datapath.sv
// ----------------------------------------------------------------------------
// qte_datapath: products, arcsine cosine term and angle registers
// One shared multiplier forms the ten component products one after another,
// a bit-pair square root forms the pitch cosine, and a shared cordic
// gives each angle in turn.
// ----------------------------------------------------------------------------
`default_nettype none
module qte_datapath
    import qte_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire qte_cmd_t           cmd,
    output qte_sts_t                sts,
    input  wire logic signed [31:0] quat_w,
    input  wire logic signed [31:0] quat_x,
    input  wire logic signed [31:0] quat_y,
    input  wire logic signed [31:0] quat_z,
    output logic signed [15:0]      roll_deg,
    output logic signed [14:0]      pitch_deg,
    output logic signed [15:0]      relative_yaw_deg
);

    localparam int Q_W = 32 - RED;
    localparam int P_W = 2 * Q_W;

    logic signed [Q_W-1:0] qw_reg, qx_reg, qy_reg, qz_reg;
    logic signed [Q_W-1:0] ma, mb;
    logic signed [P_W-1:0] prod;
    logic signed [P_W-WORK_FRAC-1:0] p14;
    logic signed [P_W-WORK_FRAC-1:0] pr_reg [10];
    logic [3:0] pidx_reg;

    logic signed [VEC_W-1:0] ry, rx, sy, yy_v, yx_v, s_sat;
    logic signed [VEC_W-1:0] vy, vx;
    logic signed [VEC_W-1:0] s_reg;

    logic [31:0] sq_n_reg, sq_r_reg, sq_b_reg;
    logic        sq_busy_reg;
    logic [31:0] sq_rb;

    logic              cd_done;
    logic signed [15:0] cd_angle;
    logic signed [15:0] roll_reg, pitch_reg, yaw_reg, actual_reg, offset_reg;
    logic signed [16:0] rel;
    logic signed [15:0] rel_w;

    // operand order: ww xx yy zz wx wy wz xy xz yz
    always_comb
    begin
        unique case (pidx_reg)
            4'd0:    begin ma = qw_reg; mb = qw_reg; end
            4'd1:    begin ma = qx_reg; mb = qx_reg; end
            4'd2:    begin ma = qy_reg; mb = qy_reg; end
            4'd3:    begin ma = qz_reg; mb = qz_reg; end
            4'd4:    begin ma = qw_reg; mb = qx_reg; end
            4'd5:    begin ma = qw_reg; mb = qy_reg; end
            4'd6:    begin ma = qw_reg; mb = qz_reg; end
            4'd7:    begin ma = qx_reg; mb = qy_reg; end
            4'd8:    begin ma = qx_reg; mb = qz_reg; end
            default: begin ma = qy_reg; mb = qz_reg; end
        endcase
        prod = ma * mb;
        p14  = prod[P_W-1:WORK_FRAC];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_quat)
        begin
            qw_reg   <= quat_w[31:RED];
            qx_reg   <= quat_x[31:RED];
            qy_reg   <= quat_y[31:RED];
            qz_reg   <= quat_z[31:RED];
            pidx_reg <= '0;
        end
        else if (cmd.prod_step)
        begin
            pr_reg[pidx_reg] <= p14;
            pidx_reg         <= pidx_reg + 1'b1;
        end
    end

    always_comb
    begin
        ry   = VEC_W'(2 * (VEC_W'(pr_reg[9]) + VEC_W'(pr_reg[4])));
        rx   = VEC_W'(1 << WORK_FRAC) - VEC_W'(2 * (VEC_W'(pr_reg[1]) + VEC_W'(pr_reg[2])));
        sy   = VEC_W'(2 * (VEC_W'(pr_reg[5]) - VEC_W'(pr_reg[8])));
        yy_v = VEC_W'(2 * (VEC_W'(pr_reg[7]) + VEC_W'(pr_reg[6])));
        yx_v = VEC_W'(pr_reg[0]) + VEC_W'(pr_reg[1]) - VEC_W'(pr_reg[2]) - VEC_W'(pr_reg[3]);
        if (sy > VEC_W'(1 << WORK_FRAC))
            s_sat = VEC_W'(1 << WORK_FRAC);
        else if (sy < -VEC_W'(1 << WORK_FRAC))
            s_sat = -VEC_W'(1 << WORK_FRAC);
        else
            s_sat = sy;
    end

    // integer square root, two bits a cycle
    assign sq_rb = sq_r_reg + sq_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_busy_reg <= 1'b0;
        else if (cmd.sqrt_start)
            sq_busy_reg <= 1'b1;
        else if (sq_busy_reg && sq_b_reg == 32'd1)
            sq_busy_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_start)
        begin
            s_reg    <= s_sat;
            sq_n_reg <= 32'(32'sd268435456 -
                            32'($signed(s_sat[15:0]) * $signed(s_sat[15:0])));
            sq_r_reg <= '0;
            sq_b_reg <= 32'h4000_0000;
        end
        else if (sq_busy_reg)
        begin
            if (sq_n_reg >= sq_rb)
            begin
                sq_n_reg <= sq_n_reg - sq_rb;
                sq_r_reg <= (sq_r_reg >> 1) + sq_b_reg;
            end
            else
                sq_r_reg <= sq_r_reg >> 1;
            sq_b_reg <= sq_b_reg >> 2;
        end
    end

    assign sts.sqrt_done   = ~sq_busy_reg;
    assign sts.cordic_done = cd_done;

    always_comb
    begin
        unique case (cmd.sel)
            SEL_ROLL:  begin vy = ry;    vx = rx; end
            SEL_PITCH: begin vy = s_reg; vx = VEC_W'(sq_r_reg); end
            SEL_YAW:   begin vy = yy_v;  vx = yx_v; end
            default:   begin vy = ry;    vx = rx; end
        endcase
    end

    qte_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.cordic_start),
        .vy    (vy),
        .vx    (vx),
        .done  (cd_done),
        .angle (cd_angle)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.store_angle)
        begin
            unique case (cmd.sel)
                SEL_ROLL:  roll_reg  <= cd_angle;
                SEL_PITCH: pitch_reg <= cd_angle;
                SEL_YAW:   yaw_reg   <= cd_angle;
                default:   roll_reg  <= cd_angle;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            actual_reg <= '0;
            offset_reg <= '0;
        end
        else if (cmd.rezero)
            offset_reg <= actual_reg;
        else if (cmd.finish)
            actual_reg <= yaw_reg;
    end

    always_comb
    begin
        rel = 17'(yaw_reg) - 17'(offset_reg);
        if (rel > 17'(ANG_LIM))
            rel = rel - 17'(2 * ANG_LIM);
        else if (rel < -17'(ANG_LIM))
            rel = rel + 17'(2 * ANG_LIM);
        rel_w = rel[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            roll_deg         <= roll_reg;
            pitch_deg        <= pitch_reg[14:0];
            relative_yaw_deg <= rel_w;
        end
    end

endmodule
`default_nettype wire

### design/qte_ctrl.sv
// ----------------------------------------------------------------------------
// qte_ctrl: sequencer for one word
// Steps the products, the square root and the three cordic runs, then
// hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module qte_ctrl
    import qte_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    input  wire logic opcode,
    input  wire logic quat_present,
    output logic      out_valid,
    input  wire logic out_stall,
    output qte_cmd_t  cmd,
    input  wire qte_sts_t sts
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_PROD  = 8'b0000_0010,
        S_ROLL  = 8'b0000_0100,
        S_SQRT  = 8'b0000_1000,
        S_PITCH = 8'b0001_0000,
        S_YAW   = 8'b0010_0000,
        S_WAIT  = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       started_reg, started_next;
    logic       ovalid_reg, ovalid_next;
    logic       accept;

    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = ovalid_reg;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        started_next = started_reg;
        ovalid_next  = ovalid_reg && out_stall;
        cmd          = '0;
        cmd.sel      = SEL_ROLL;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (opcode)
                        cmd.rezero = 1'b1;
                    else if (quat_present)
                    begin
                        cmd.load_quat = 1'b1;
                        cnt_next      = '0;
                        state_next    = S_PROD;
                    end
                end
            end
            S_PROD:
            begin
                cmd.prod_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == 4'd9)
                begin
                    started_next = 1'b0;
                    state_next   = S_ROLL;
                end
            end
            S_ROLL:
            begin
                cmd.sel = SEL_ROLL;
                if (!started_reg)
                begin
                    cmd.cordic_start = 1'b1;
                    started_next     = 1'b1;
                end
                else if (sts.cordic_done)
                begin
                    cmd.store_angle = 1'b1;
                    cmd.sqrt_start  = 1'b1;
                    started_next    = 1'b0;
                    state_next      = S_SQRT;
                end
            end
            S_SQRT:
            begin
                cmd.sel = SEL_PITCH;
                if (started_reg && sts.sqrt_done)
                begin
                    started_next = 1'b0;
                    state_next   = S_PITCH;
                end
                else
                    started_next = 1'b1;
            end
            S_PITCH:
            begin
                cmd.sel = SEL_PITCH;
                if (!started_reg)
                begin
                    cmd.cordic_start = 1'b1;
                    started_next     = 1'b1;
                end
                else if (sts.cordic_done)
                begin
                    cmd.store_angle = 1'b1;
                    started_next    = 1'b0;
                    state_next      = S_YAW;
                end
            end
            S_YAW:
            begin
                cmd.sel = SEL_YAW;
                if (!started_reg)
                begin
                    cmd.cordic_start = 1'b1;
                    started_next     = 1'b1;
                end
                else if (sts.cordic_done)
                begin
                    cmd.store_angle = 1'b1;
                    state_next      = S_WAIT;
                end
            end
            S_WAIT:
            begin
                // previous word must be gone before the output register reloads
                cmd.sel = SEL_YAW;
                if (!ovalid_reg || !out_stall)
                begin
                    cmd.finish  = 1'b1;
                    ovalid_next = 1'b1;
                    state_next  = S_OUT;
                end
            end
            S_OUT:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            started_reg <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            started_reg <= started_next;
            ovalid_reg  <= ovalid_next;
        end
    end

endmodule
`default_nettype wire

### design/quaternion_to_euler_rezero_top.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_rezero_top: quaternion to roll, pitch, relative yaw
// Controller plus datapath with a shared cordic and square root unit.
// ----------------------------------------------------------------------------
//  channel | handshake            | fields
//  input   | in_valid / in_stall  | opcode quat_present quat_w/x/y/z
//  output  | out_valid / out_stall| roll_deg pitch_deg relative_yaw_deg
//
// a sample word runs ten products on one multiplier, the roll cordic run,
// the square root, then the pitch and yaw cordic runs, each cordic run of
// 16 steps after its normalize shifts; re-zero and empty words are handled
// in the idle state itself.
// reset clears the controller and sets the stored actual yaw and the offset to zero.
// the output register holds a word while out_stall is high; a new word
// is accepted meanwhile and waits only at its final load.
// ----------------------------------------------------------------------------
`default_nettype none
module quaternion_to_euler_rezero_top
    import qte_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               opcode,
    input  wire logic               quat_present,
    input  wire logic signed [31:0] quat_w,
    input  wire logic signed [31:0] quat_x,
    input  wire logic signed [31:0] quat_y,
    input  wire logic signed [31:0] quat_z,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [15:0]      roll_deg,
    output logic signed [14:0]      pitch_deg,
    output logic signed [15:0]      relative_yaw_deg
);

    qte_cmd_t cmd;
    qte_sts_t sts;

    qte_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .quat_present (quat_present),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .cmd          (cmd),
        .sts          (sts)
    );

    qte_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .quat_w           (quat_w),
        .quat_x           (quat_x),
        .quat_y           (quat_y),
        .quat_z           (quat_z),
        .roll_deg         (roll_deg),
        .pitch_deg        (pitch_deg),
        .relative_yaw_deg (relative_yaw_deg)
    );

endmodule
`default_nettype wire
